/* hw/rtl/rmat_edge_quadrant_walk_macros.svh */
// Assertion macros for the R-MAT edge quadrant walk
`ifndef RMAT_EDGE_QUADRANT_WALK_MACROS_SVH
`define RMAT_EDGE_QUADRANT_WALK_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset
`define RMAT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Checked at every edge, reset included
`define RMAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RMAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/rmat_eqw_pkg.sv */
// Shared types and constants of the R-MAT edge quadrant walk
`default_nettype none
package rmat_eqw_pkg;
	localparam int PROB_W  = 17;               // Q1.16 probability
	localparam int FRAC_W  = 16;               // Q0.16 random fraction
	localparam int SCALE_W = 6;                // level count and level register
	localparam int VERT_W  = 32;               // vertex index
	localparam int JIT_W   = 18;               // jittered probability
	localparam int SUM_W   = 20;               // sum of four jittered probabilities
	localparam int MULT_W  = 20;               // 9.5 * 2^16 + jitter
	localparam int PROD_W  = PROB_W + MULT_W;  // full jitter product
	localparam int CFG_IDX_W = 3;

	localparam logic [MULT_W-1:0] JIT_BASE = 20'd622592;
	localparam logic [PROB_W-1:0] ONE_Q16  = 17'd65536;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_C       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_D       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEVELS = 3'd4;

	// Register reset values
	localparam logic [PROB_W-1:0]  PROB_A_RST = 17'd36045;
	localparam logic [PROB_W-1:0]  PROB_B_RST = 17'd6554;
	localparam logic [PROB_W-1:0]  PROB_C_RST = 17'd6554;
	localparam logic [PROB_W-1:0]  PROB_D_RST = 17'd16384;
	localparam logic [SCALE_W-1:0] LEVELS_RST = 6'd20;

	typedef struct packed {
		logic [FRAC_W-1:0] rand_pick;
		logic [FRAC_W-1:0] rand_jitter_a;
		logic [FRAC_W-1:0] rand_jitter_b;
		logic [FRAC_W-1:0] rand_jitter_c;
		logic [FRAC_W-1:0] rand_jitter_d;
	} in_item_t;

	typedef struct packed {
		logic [VERT_W-1:0] src_vertex;
		logic [VERT_W-1:0] dst_vertex;
	} out_item_t;

	typedef enum logic [1:0] {JIT_IDLE, JIT_MUL, JIT_ADJ, JIT_DIV} jit_state_t;
	typedef enum logic {NRM_IDLE, NRM_DIV} nrm_state_t;
	typedef enum logic [1:0] {ST_IDLE, ST_JITTER, ST_SUM, ST_NORM} walk_state_t;
endpackage
`default_nettype wire

/* hw/rtl/rmat_eqw_jitter.sv */
// Bit-serial jitter lane: round((x * (622592 + j)) / 655360)
`default_nettype none
module rmat_eqw_jitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rmat_eqw_pkg::PROB_W-1:0]   prob,
	input  logic [rmat_eqw_pkg::FRAC_W-1:0]   jit,
	output logic                              done,
	output logic [rmat_eqw_pkg::JIT_W-1:0]    result
);
	import rmat_eqw_pkg::*;

	localparam int CNT_W = 5;
	localparam int HI_W  = PROD_W - FRAC_W;   // product over 2^16
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MULT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(JIT_W - 1);
	localparam logic [4:0]       TEN      = 5'd10;
	localparam logic [HI_W-1:0]  HALF_TEN = HI_W'(5);

	jit_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROB_W-1:0] x_q;
	logic [PROD_W-1:0] prod_q;
	logic [JIT_W-1:0]  quo_q;
	logic [3:0]        rem_q;

	logic [PROB_W:0]   part_sum;
	logic [HI_W-1:0]   scaled;
	logic [4:0]        trial;
	logic [4:0]        trial_sub;
	logic              trial_ge;

	// Shift-add step, divide-by-ten step
	assign part_sum  = {1'b0, prod_q[PROD_W-1:MULT_W]} + (prod_q[0] ? {1'b0, x_q} : '0);
	assign scaled    = prod_q[PROD_W-1:FRAC_W] + HALF_TEN;
	assign trial     = {rem_q, quo_q[JIT_W-1]};
	assign trial_ge  = (trial >= TEN);
	assign trial_sub = trial - TEN;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			JIT_IDLE: if (start) state_d = JIT_MUL;
			JIT_MUL:  if (cnt_q == MUL_LAST) state_d = JIT_ADJ;
			JIT_ADJ:  state_d = JIT_DIV;
			JIT_DIV:  if (cnt_q == DIV_LAST) state_d = JIT_IDLE;
			default:  state_d = JIT_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= JIT_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == JIT_DIV) && (cnt_q == DIV_LAST);
			if ((state_q == JIT_MUL && cnt_q != MUL_LAST) ||
			    (state_q == JIT_DIV && cnt_q != DIV_LAST))
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// Datapath: multiplier bits shift out at the bottom, quotient bits shift in
	always_ff @(posedge clk) begin
		case (state_q)
			JIT_IDLE: begin
				if (start) begin
					x_q    <= prob;
					prod_q <= {{PROB_W{1'b0}}, JIT_BASE + {{(MULT_W-FRAC_W){1'b0}}, jit}};
				end
			end
			JIT_MUL: begin
				prod_q <= {part_sum, prod_q[MULT_W-1:1]};
			end
			JIT_ADJ: begin
				// High bits are below ten, so the quotient fits JIT_W bits
				quo_q <= scaled[JIT_W-1:0];
				rem_q <= {1'b0, scaled[HI_W-1:JIT_W]};
			end
			JIT_DIV: begin
				quo_q <= {quo_q[JIT_W-2:0], trial_ge};
				rem_q <= trial_ge ? trial_sub[3:0] : trial[3:0];
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/rmat_eqw_norm.sv */
// Bit-serial normalizer: round(num * 65536 / den), restoring division
`default_nettype none
module rmat_eqw_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rmat_eqw_pkg::JIT_W-1:0]    num,
	input  logic [rmat_eqw_pkg::SUM_W-1:0]    den,
	output logic                              done,
	output logic [rmat_eqw_pkg::PROB_W-1:0]   quo
);
	import rmat_eqw_pkg::*;

	localparam int CNT_W = 5;
	localparam int NUM_W = JIT_W + FRAC_W;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(PROB_W - 1);

	nrm_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [SUM_W-1:0]  den_q;
	logic [SUM_W-1:0]  rem_q;
	logic [PROB_W-1:0] quo_q;

	logic [NUM_W-1:0]  dividend;
	logic [SUM_W:0]    trial;
	logic [SUM_W:0]    trial_sub;
	logic              trial_ge;

	// Numerator with half the divisor added for rounding
	assign dividend  = {num, {FRAC_W{1'b0}}} + NUM_W'(den[SUM_W-1:1]);
	assign trial     = {rem_q, quo_q[PROB_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			NRM_IDLE: if (start) state_d = NRM_DIV;
			NRM_DIV:  if (cnt_q == LAST) state_d = NRM_IDLE;
			default:  state_d = NRM_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NRM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == NRM_DIV) && (cnt_q == LAST);
			if (state_q == NRM_DIV && cnt_q != LAST)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// Quotient stays below 2^17, so the top dividend bits start as remainder
	always_ff @(posedge clk) begin
		if (state_q == NRM_IDLE) begin
			if (start) begin
				den_q <= den;
				rem_q <= SUM_W'(dividend[NUM_W-1:PROB_W]);
				quo_q <= dividend[PROB_W-1:0];
			end
		end else begin
			quo_q <= {quo_q[PROB_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/rmat_edge_quadrant_walk.sv */
// R-MAT edge quadrant walk: top level with control, config and output register
//
// Usage: each input transaction carries one level's random fractions (pick and
// four jitters). The pick selects a quadrant and sets one row and one column bit,
// most significant first. After scale_levels transactions one output transaction
// carries the finished edge (src_vertex, dst_vertex).
// Non-final level: four bit-serial jitter lanes run 20 multiply steps, one
// rounding step and 18 divide-by-ten steps; the jittered values are summed,
// and three serial normalizers run 17 steps. Input waits until this is done.
// Final level: no arithmetic runs; the edge appears on out_valid the next cycle.
// The output register holds the edge while out_stall is high; meanwhile new
// levels of the next edge are still taken, only its final level waits.
// Config writes are always ready; probability writes take effect at the next
// edge start, a level count write at once.
// Reset clears the level count and the edge bits, restores the register
// defaults and leaves no result pending.
`include "rmat_edge_quadrant_walk_macros.svh"
`default_nettype none
module rmat_edge_quadrant_walk #(
	parameter int MAX_SCALE = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rmat_eqw_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rmat_eqw_pkg::out_item_t             out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rmat_eqw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rmat_eqw_pkg::PROB_W-1:0]     cfg_data
);
	import rmat_eqw_pkg::*;

	localparam int RW = (MAX_SCALE > VERT_W) ? MAX_SCALE : VERT_W;

	walk_state_t        state_q, state_d;
	logic [PROB_W-1:0]  prob_q [4];
	logic [SCALE_W-1:0] levels_cfg_q;
	logic [PROB_W-1:0]  cur_q [4];
	logic [SCALE_W-1:0] lvl_q;
	logic [RW-1:0]      row_q;
	logic [RW-1:0]      col_q;
	logic [SUM_W-1:0]   sum_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [SCALE_W-1:0] levels;
	logic               last_now;
	logic [SCALE_W-1:0] pos;
	logic               accept;
	logic               jit_start;
	logic [PROB_W-1:0]  op [4];
	logic [FRAC_W-1:0]  jit_in [4];
	logic [3:0]         jit_done;
	logic [JIT_W-1:0]   jit_res [4];
	logic [2:0]         nrm_done;
	logic [PROB_W-1:0]  nrm_res [3];
	logic [PROB_W-1:0]  new_abc [3];
	logic [PROB_W+1:0]  abc_sum;
	logic [PROB_W-1:0]  new_d;
	logic [PROB_W:0]    sum_ab;
	logic [PROB_W+1:0]  sum_abc;
	logic [FRAC_W-1:0]  pick;
	logic               set_row;
	logic               set_col;
	logic [RW-1:0]      mask;
	logic [RW-1:0]      row_new;
	logic [RW-1:0]      col_new;

	// Level count clamped to 1..MAX_SCALE
	always_comb begin
		if (levels_cfg_q == '0)
			levels = SCALE_W'(1);
		else if (levels_cfg_q > SCALE_W'(MAX_SCALE))
			levels = SCALE_W'(MAX_SCALE);
		else
			levels = levels_cfg_q;
	end

	assign last_now = ({1'b0, lvl_q} + (SCALE_W+1)'(1)) >= {1'b0, levels};
	assign pos      = last_now ? '0 : (levels - lvl_q - SCALE_W'(1));

	// Input handshake: busy while the arithmetic runs, final level waits on output
	assign in_stall  = (state_q != ST_IDLE) | (out_valid_q & out_stall & last_now);
	assign accept    = in_valid & ~in_stall;
	assign jit_start = accept & ~last_now;
	assign cfg_ready = 1'b1;

	// Edge start takes the configured probabilities
	always_comb begin
		for (int i = 0; i < 4; i++)
			op[i] = (lvl_q == '0) ? prob_q[i] : cur_q[i];
	end

	assign jit_in[0] = in_data.rand_jitter_a;
	assign jit_in[1] = in_data.rand_jitter_b;
	assign jit_in[2] = in_data.rand_jitter_c;
	assign jit_in[3] = in_data.rand_jitter_d;

	// Quadrant pick
	assign pick    = in_data.rand_pick;
	assign sum_ab  = {1'b0, op[0]} + {1'b0, op[1]};
	assign sum_abc = {1'b0, sum_ab} + {2'b0, op[2]};
	assign set_row = {2'b0, pick} > sum_ab;
	assign set_col = ({2'b0, pick} > {1'b0, op[0]}) &&
	                 (({2'b0, pick} <= sum_ab) || ({3'b0, pick} > sum_abc));
	assign mask    = RW'(1) << pos;
	assign row_new = ((lvl_q == '0) ? '0 : row_q) | (set_row ? mask : '0);
	assign col_new = ((lvl_q == '0) ? '0 : col_q) | (set_col ? mask : '0);

	// Jitter lanes
	for (genvar g = 0; g < 4; g++) begin : g_jit
		rmat_eqw_jitter u_jit (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (jit_start),
			.prob   (op[g]),
			.jit    (jit_in[g]),
			.done   (jit_done[g]),
			.result (jit_res[g])
		);
	end

	// Normalizers for A, B and C
	for (genvar g = 0; g < 3; g++) begin : g_nrm
		rmat_eqw_norm u_nrm (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_SUM),
			.num    (jit_res[g]),
			.den    (sum_q),
			.done   (nrm_done[g]),
			.quo    (nrm_res[g])
		);
	end

	// New probabilities; an all-zero sum gives A = B = C = 0
	always_comb begin
		for (int i = 0; i < 3; i++)
			new_abc[i] = (sum_q == '0) ? '0 : nrm_res[i];
		abc_sum = {2'b0, new_abc[0]} + {2'b0, new_abc[1]} + {2'b0, new_abc[2]};
		if (abc_sum >= (PROB_W+2)'(ONE_Q16))
			new_d = '0;
		else
			new_d = PROB_W'((PROB_W+2)'(ONE_Q16) - abc_sum);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (jit_start) state_d = ST_JITTER;
			ST_JITTER: if (jit_done[0]) state_d = ST_SUM;
			ST_SUM:    state_d = ST_NORM;
			ST_NORM:   if (nrm_done[0]) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Walk state, config and probabilities
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prob_q[0]    <= PROB_A_RST;
			prob_q[1]    <= PROB_B_RST;
			prob_q[2]    <= PROB_C_RST;
			prob_q[3]    <= PROB_D_RST;
			levels_cfg_q <= LEVELS_RST;
			cur_q[0]     <= PROB_A_RST;
			cur_q[1]     <= PROB_B_RST;
			cur_q[2]     <= PROB_C_RST;
			cur_q[3]     <= PROB_D_RST;
			lvl_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_PROB_A:       prob_q[0]    <= cfg_data;
					CFG_PROB_B:       prob_q[1]    <= cfg_data;
					CFG_PROB_C:       prob_q[2]    <= cfg_data;
					CFG_PROB_D:       prob_q[3]    <= cfg_data;
					CFG_SCALE_LEVELS: levels_cfg_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (last_now) begin
					lvl_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end else begin
					lvl_q <= lvl_q + SCALE_W'(1);
					row_q <= row_new;
					col_q <= col_new;
				end
			end

			if (state_q == ST_NORM && nrm_done[0]) begin
				cur_q[0] <= new_abc[0];
				cur_q[1] <= new_abc[1];
				cur_q[2] <= new_abc[2];
				cur_q[3] <= new_d;
			end

			if (accept && last_now)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_JITTER && jit_done[0])
			sum_q <= SUM_W'(jit_res[0]) + SUM_W'(jit_res[1]) +
			         SUM_W'(jit_res[2]) + SUM_W'(jit_res[3]);
		if (accept && last_now) begin
			out_q.src_vertex <= row_new[VERT_W-1:0];
			out_q.dst_vertex <= col_new[VERT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	`RMAT_ASSERT(a_jit_lockstep, clk, arst_n, (jit_done == 4'b0000) || (jit_done == 4'b1111), "jitter lanes out of step")
	`RMAT_ASSERT(a_nrm_lockstep, clk, arst_n, (nrm_done == 3'b000) || (nrm_done == 3'b111), "normalizers out of step")
	`RMAT_ASSERT(a_no_overwrite, clk, arst_n, (out_valid_q && out_stall && accept) |-> !last_now, "pending edge overwritten")
	`RMAT_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!out_valid && !in_stall), "activity during reset")
endmodule
`default_nettype wire
